/* design/shbe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbe_pkg
// Shared constants, command and status types, and coefficient tables for the
// spherical harmonic basis evaluator.
// ----------------------------------------------------------------------------
package shbe_pkg;

  // Block configuration.
  localparam int MAX_BANDS       = 8;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int OUT_FRAC_BITS   = 16;

  // Field widths.
  localparam int BAND_IN_W  = 3;
  localparam int ORDER_W    = 4;
  localparam int POLAR_W    = ANGLE_FRAC_BITS + 2;
  localparam int AZIM_W     = ANGLE_FRAC_BITS + 3;
  localparam int VALUE_W    = 18;
  localparam int MAG_W      = ORDER_W;

  // Internal widths.
  localparam int BAND_W     = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int BAND_N     = 1 << BAND_W;
  localparam int CORDIC_STEPS = 30;
  localparam int CNT_W      = $clog2(CORDIC_STEPS);
  localparam int ANG_W      = 36;
  localparam int ZW         = 36;
  localparam int OPW        = 34;
  localparam int PROD_W     = 2 * OPW;
  localparam int COEF_W     = 28;
  localparam int MOD_STEPS  = 4;
  localparam int ANG_SHIFT  = 30 - ANGLE_FRAC_BITS;
  localparam int OUT_SHIFT  = 30 - OUT_FRAC_BITS;
  localparam int MP_W       = MAG_W + AZIM_W;

  // Fixed-point constants in Q.30.
  localparam longint Q30_PI       = 64'd3373259426;
  localparam longint Q30_TWO_PI   = 2 * Q30_PI;
  localparam longint Q30_HALF_PI  = Q30_PI / 2;
  localparam longint Q30_SQRT2    = 64'd1518500250;
  localparam longint Q30_INV_S4PI = 64'd302896976;
  localparam longint CORDIC_GAIN  = 64'h26DD3B6A;
  localparam longint VAL_MAX      = 131071;
  localparam longint VAL_MIN      = -131072;

  typedef logic signed [ZW-1:0] zval_t;
  typedef zval_t atan_tab_t [CORDIC_STEPS];

  localparam atan_tab_t ATAN_TAB = '{
    36'sh03243F6A8, 36'sh01DAC6705, 36'sh00FADBAFC, 36'sh007F56EA6, 36'sh003FEAB76,
    36'sh001FFD55B, 36'sh000FFFAAA, 36'sh0007FFF55, 36'sh0003FFFEA, 36'sh0001FFFFD,
    36'sh0000FFFFF, 36'sh00007FFFF, 36'sh00003FFFF, 36'sh00001FFFF, 36'sh00000FFFF,
    36'sh000007FFF, 36'sh000003FFF, 36'sh000001FFF, 36'sh000000FFF, 36'sh0000007FF,
    36'sh0000003FF, 36'sh0000001FF, 36'sh0000000FF, 36'sh00000007F, 36'sh00000003F,
    36'sh00000001F, 36'sh00000000F, 36'sh000000008, 36'sh000000004, 36'sh000000002
  };

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PHI,
    OP_MOD,
    OP_FOLD,
    OP_ROT,
    OP_TRIG,
    OP_MUL,
    OP_RND,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    A_PREV,
    A_CUR,
    A_T,
    A_RES
  } asel_t;

  typedef enum logic [2:0] {
    B_SN,
    B_CX,
    B_C1,
    B_C0,
    B_CA,
    B_CB,
    B_SQRT2,
    B_TRG
  } bsel_t;

  typedef enum logic [2:0] {
    WB_PREV,
    WB_PREV_NEG,
    WB_T,
    WB_CUR,
    WB_T_SUB,
    WB_SHIFT
  } wb_t;

  typedef struct packed {
    op_t              op;
    asel_t            a_sel;
    bsel_t            b_sel;
    logic             rnd24;
    wb_t              wb;
    logic [CNT_W-1:0] idx;
    logic             pass;
  } cmd_t;

  typedef struct packed {
    logic [BAND_IN_W-1:0] band;
    logic [MAG_W-1:0]     mag;
    logic                 bad;
    logic                 m_zero;
    logic                 out_hold;
  } status_t;

  // Coefficient tables, built at elaboration.
  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t coef_row_t [BAND_N];
  typedef coef_t coef_mat_t [BAND_N*BAND_N];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (b > v) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Square root of num/den in Q.24; zero where the ratio is meaningless.
  function automatic coef_t sqrt_ratio(input longint num, input longint den);
    logic [63:0] q;
    if (den <= 0 || num < 0) return '0;
    q = udiv64(64'(num) << 48, 64'(den));
    return COEF_W'(isqrt64(q));
  endfunction

  function automatic coef_row_t build_c1();
    coef_row_t t;
    for (int k = 0; k < BAND_N; k++) t[k] = sqrt_ratio(2 * k + 1, 2 * k);
    return t;
  endfunction

  function automatic coef_row_t build_c0();
    coef_row_t t;
    for (int m = 0; m < BAND_N; m++) t[m] = sqrt_ratio(2 * m + 3, 1);
    return t;
  endfunction

  function automatic coef_mat_t build_ca();
    coef_mat_t t;
    for (int k = 0; k < BAND_N; k++)
      for (int m = 0; m < BAND_N; m++)
        t[k*BAND_N+m] = sqrt_ratio(4 * k * k - 1, k * k - m * m);
    return t;
  endfunction

  function automatic coef_mat_t build_cb();
    coef_mat_t t;
    for (int k = 0; k < BAND_N; k++)
      for (int m = 0; m < BAND_N; m++)
        t[k*BAND_N+m] = sqrt_ratio((k - 1) * (k - 1) - m * m, 4 * (k - 1) * (k - 1) - 1);
    return t;
  endfunction

  localparam coef_row_t C1_TAB = build_c1();
  localparam coef_row_t C0_TAB = build_c0();
  localparam coef_mat_t CA_TAB = build_ca();
  localparam coef_mat_t CB_TAB = build_cb();

endpackage

/* design/shbe_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbe_datapath
// Angle reduction, shared CORDIC rotator, single multiplier with rounding
// write-back, and the output register.
// ----------------------------------------------------------------------------
module shbe_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  shbe_pkg::cmd_t                          cmd,
  output shbe_pkg::status_t                       status,
  input  logic [shbe_pkg::BAND_IN_W-1:0]          in_band,
  input  logic signed [shbe_pkg::ORDER_W-1:0]     in_order,
  input  logic [shbe_pkg::POLAR_W-1:0]            in_polar_angle,
  input  logic [shbe_pkg::AZIM_W-1:0]             in_azimuth_angle,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [shbe_pkg::VALUE_W-1:0]     out_basis_value,
  output logic                                    out_bad_order
);

  localparam logic [shbe_pkg::ANG_W-1:0] TWO_PI_A = shbe_pkg::ANG_W'(shbe_pkg::Q30_TWO_PI);
  localparam logic [shbe_pkg::ANG_W-1:0] PI_A     = shbe_pkg::ANG_W'(shbe_pkg::Q30_PI);
  localparam shbe_pkg::zval_t TWO_PI_Z  = shbe_pkg::ZW'(shbe_pkg::Q30_TWO_PI);
  localparam shbe_pkg::zval_t PI_Z      = shbe_pkg::ZW'(shbe_pkg::Q30_PI);
  localparam shbe_pkg::zval_t HALF_PI_Z = shbe_pkg::ZW'(shbe_pkg::Q30_HALF_PI);
  localparam shbe_pkg::zval_t GAIN_Z    = shbe_pkg::ZW'(shbe_pkg::CORDIC_GAIN);
  localparam logic signed [shbe_pkg::PROD_W-1:0] BIAS24 = shbe_pkg::PROD_W'(1) <<< 23;
  localparam logic signed [shbe_pkg::PROD_W-1:0] BIAS30 = shbe_pkg::PROD_W'(1) <<< 29;
  localparam logic signed [shbe_pkg::OPW-1:0] OUT_BIAS =
    (shbe_pkg::OUT_SHIFT > 0) ? (shbe_pkg::OPW'(1) <<< (shbe_pkg::OUT_SHIFT - 1)) : '0;
  localparam logic signed [shbe_pkg::OPW-1:0] SAT_HI = shbe_pkg::OPW'(shbe_pkg::VAL_MAX);
  localparam logic signed [shbe_pkg::OPW-1:0] SAT_LO = shbe_pkg::OPW'(shbe_pkg::VAL_MIN);

  // Request registers.
  logic [shbe_pkg::BAND_IN_W-1:0] band_r;
  logic [shbe_pkg::MAG_W-1:0]     mag_r;
  logic                           m_pos_r;
  logic                           m_zero_r;
  logic                           bad_r;
  logic [shbe_pkg::AZIM_W-1:0]    azim_r;

  // Angle and rotator registers.
  logic [shbe_pkg::ANG_W-1:0] ang_r;
  shbe_pkg::zval_t            x_r, y_r, z_r;
  logic                       neg_r;

  // Arithmetic registers.
  logic signed [shbe_pkg::OPW-1:0]    prev_r, cur_r, t_r, cx_r, sn_r, trg_r;
  logic signed [shbe_pkg::PROD_W-1:0] prod_r;

  // Output register.
  logic                               out_valid_r;
  logic signed [shbe_pkg::VALUE_W-1:0] value_r;
  logic                               bad_out_r;

  // Input decode.
  logic [shbe_pkg::MAG_W-1:0] in_mag;
  logic                       in_bad;
  assign in_mag = in_order[shbe_pkg::ORDER_W-1] ? shbe_pkg::MAG_W'(-in_order)
                                                : shbe_pkg::MAG_W'(in_order);
  assign in_bad = (32'(in_band) >= 32'(shbe_pkg::MAX_BANDS)) ||
                  ({1'b0, in_mag} > (shbe_pkg::MAG_W + 1)'(in_band));

  // Azimuth angle scaled by the order magnitude.
  logic [shbe_pkg::MP_W-1:0] mp;
  assign mp = shbe_pkg::MP_W'(mag_r) * shbe_pkg::MP_W'(azim_r);

  // Modulo step and fold into the rotator's range.
  logic [shbe_pkg::ANG_W-1:0] mod_sub;
  shbe_pkg::zval_t            z0;
  assign mod_sub = TWO_PI_A << cmd.idx;
  assign z0 = (ang_r > PI_A) ? (shbe_pkg::zval_t'(ang_r) - TWO_PI_Z) : shbe_pkg::zval_t'(ang_r);

  // One rotator step.
  shbe_pkg::zval_t x_sh, y_sh, xs, ys, ys_abs;
  assign x_sh   = x_r >>> cmd.idx;
  assign y_sh   = y_r >>> cmd.idx;
  assign xs     = neg_r ? -x_r : x_r;
  assign ys     = neg_r ? -y_r : y_r;
  assign ys_abs = ys[shbe_pkg::ZW-1] ? -ys : ys;

  // Coefficient lookup.
  logic [shbe_pkg::BAND_W-1:0]   k_idx, m_idx;
  logic [2*shbe_pkg::BAND_W-1:0] km_idx;
  assign k_idx  = cmd.idx[shbe_pkg::BAND_W-1:0];
  assign m_idx  = mag_r[shbe_pkg::BAND_W-1:0];
  assign km_idx = {k_idx, m_idx};

  // Multiplier operands.
  logic signed [shbe_pkg::OPW-1:0] res, op_a, op_b;
  shbe_pkg::coef_t                 coef;
  logic                            use_coef;
  assign res = (32'(band_r) > 32'(mag_r)) ? cur_r : prev_r;

  always_comb begin
    case (cmd.a_sel)
      shbe_pkg::A_PREV: op_a = prev_r;
      shbe_pkg::A_CUR:  op_a = cur_r;
      shbe_pkg::A_T:    op_a = t_r;
      default:          op_a = res;
    endcase
  end

  always_comb begin
    coef     = '0;
    use_coef = 1'b1;
    op_b     = '0;
    case (cmd.b_sel)
      shbe_pkg::B_C1: coef = shbe_pkg::C1_TAB[k_idx];
      shbe_pkg::B_C0: coef = shbe_pkg::C0_TAB[m_idx];
      shbe_pkg::B_CA: coef = shbe_pkg::CA_TAB[km_idx];
      shbe_pkg::B_CB: coef = shbe_pkg::CB_TAB[km_idx];
      default:        use_coef = 1'b0;
    endcase
    if (use_coef) begin
      op_b = signed'({{(shbe_pkg::OPW - shbe_pkg::COEF_W){1'b0}}, coef});
    end else begin
      case (cmd.b_sel)
        shbe_pkg::B_SN:    op_b = sn_r;
        shbe_pkg::B_CX:    op_b = cx_r;
        shbe_pkg::B_SQRT2: op_b = shbe_pkg::OPW'(shbe_pkg::Q30_SQRT2);
        default:           op_b = trg_r;
      endcase
    end
  end

  // Rounded product.
  logic signed [shbe_pkg::PROD_W-1:0] rnd_full;
  logic signed [shbe_pkg::OPW-1:0]    rnd;
  assign rnd_full = cmd.rnd24 ? ((prod_r + BIAS24) >>> 24) : ((prod_r + BIAS30) >>> 30);
  assign rnd      = rnd_full[shbe_pkg::OPW-1:0];

  // Final rounding and saturation.
  logic signed [shbe_pkg::OPW-1:0] fin, fin_r;
  logic signed [shbe_pkg::VALUE_W-1:0] fin_sat;
  assign fin   = m_zero_r ? res : t_r;
  assign fin_r = (fin + OUT_BIAS) >>> shbe_pkg::OUT_SHIFT;
  always_comb begin
    if (fin_r > SAT_HI)      fin_sat = shbe_pkg::VALUE_W'(SAT_HI);
    else if (fin_r < SAT_LO) fin_sat = shbe_pkg::VALUE_W'(SAT_LO);
    else                     fin_sat = fin_r[shbe_pkg::VALUE_W-1:0];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      shbe_pkg::OP_LOAD: begin
        band_r   <= in_band;
        mag_r    <= in_mag;
        m_pos_r  <= !in_order[shbe_pkg::ORDER_W-1] && (in_order != '0);
        m_zero_r <= (in_order == '0);
        bad_r    <= in_bad;
        azim_r   <= in_azimuth_angle;
        ang_r    <= shbe_pkg::ANG_W'(in_polar_angle) << shbe_pkg::ANG_SHIFT;
        prev_r   <= shbe_pkg::OPW'(shbe_pkg::Q30_INV_S4PI);
      end
      shbe_pkg::OP_PHI: begin
        ang_r <= shbe_pkg::ANG_W'(mp) << shbe_pkg::ANG_SHIFT;
      end
      shbe_pkg::OP_MOD: begin
        if (ang_r >= mod_sub) ang_r <= ang_r - mod_sub;
      end
      shbe_pkg::OP_FOLD: begin
        x_r <= GAIN_Z;
        y_r <= '0;
        if (z0 > HALF_PI_Z) begin
          z_r   <= z0 - PI_Z;
          neg_r <= 1'b1;
        end else if (z0 < -HALF_PI_Z) begin
          z_r   <= z0 + PI_Z;
          neg_r <= 1'b1;
        end else begin
          z_r   <= z0;
          neg_r <= 1'b0;
        end
      end
      shbe_pkg::OP_ROT: begin
        if (!z_r[shbe_pkg::ZW-1]) begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - shbe_pkg::ATAN_TAB[cmd.idx];
        end else begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + shbe_pkg::ATAN_TAB[cmd.idx];
        end
      end
      shbe_pkg::OP_TRIG: begin
        if (!cmd.pass) begin
          cx_r <= xs[shbe_pkg::OPW-1:0];
          sn_r <= ys_abs[shbe_pkg::OPW-1:0];
        end else begin
          trg_r <= m_pos_r ? xs[shbe_pkg::OPW-1:0] : ys[shbe_pkg::OPW-1:0];
        end
      end
      shbe_pkg::OP_MUL: begin
        prod_r <= shbe_pkg::PROD_W'(op_a) * shbe_pkg::PROD_W'(op_b);
      end
      shbe_pkg::OP_RND: begin
        case (cmd.wb)
          shbe_pkg::WB_PREV:     prev_r <= rnd;
          shbe_pkg::WB_PREV_NEG: prev_r <= -rnd;
          shbe_pkg::WB_T:        t_r    <= rnd;
          shbe_pkg::WB_CUR:      cur_r  <= rnd;
          shbe_pkg::WB_T_SUB:    t_r    <= t_r - rnd;
          default: begin
            prev_r <= cur_r;
            cur_r  <= rnd;
          end
        endcase
      end
      shbe_pkg::OP_OUT: begin
        value_r   <= bad_r ? '0 : fin_sat;
        bad_out_r <= bad_r;
      end
      default: ;
    endcase
  end

  // Output beat valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == shbe_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_basis_value = value_r;
  assign out_bad_order   = bad_out_r;

  assign status.band     = band_r;
  assign status.mag      = mag_r;
  assign status.bad      = bad_r;
  assign status.m_zero   = m_zero_r;
  assign status.out_hold = out_valid_r && !out_ready;

endmodule

/* design/shbe_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shbe_ctrl
// Sequencer that steps the datapath through angle reduction, the CORDIC
// passes, the Legendre recurrence and the azimuth factor.
// ----------------------------------------------------------------------------
module shbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shbe_pkg::status_t   status,
  output shbe_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_MOD, S_FOLD, S_ROT, S_TRIG,
    S_SEC, S_SEED, S_REC, S_PHI, S_AZI, S_OUT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [2:0]                 sub_r, sub_nxt;
  logic [shbe_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       pass_r, pass_nxt;

  logic [shbe_pkg::CNT_W-1:0] band_c, mag_c;
  logic                       has_rec;
  state_t                     post_state;
  assign band_c     = shbe_pkg::CNT_W'(status.band);
  assign mag_c      = shbe_pkg::CNT_W'(status.mag);
  assign has_rec    = band_c > mag_c;
  assign post_state = status.m_zero ? S_OUT : S_PHI;

  // Command decode and next state.
  always_comb begin
    cmd       = '{op: shbe_pkg::OP_NONE, a_sel: shbe_pkg::A_PREV, b_sel: shbe_pkg::B_SN,
                  rnd24: 1'b0, wb: shbe_pkg::WB_PREV, idx: cnt_r, pass: pass_r};
    state_nxt = state_r;
    sub_nxt   = sub_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = shbe_pkg::OP_LOAD;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (status.bad) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MOD;
          cnt_nxt   = shbe_pkg::CNT_W'(shbe_pkg::MOD_STEPS - 1);
          pass_nxt  = 1'b0;
        end
      end
      S_MOD: begin
        cmd.op = shbe_pkg::OP_MOD;
        if (cnt_r == '0) state_nxt = S_FOLD;
        else cnt_nxt = cnt_r - 1'b1;
      end
      S_FOLD: begin
        cmd.op    = shbe_pkg::OP_FOLD;
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op = shbe_pkg::OP_ROT;
        if (cnt_r == shbe_pkg::CNT_W'(shbe_pkg::CORDIC_STEPS - 1)) state_nxt = S_TRIG;
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_TRIG: begin
        cmd.op  = shbe_pkg::OP_TRIG;
        sub_nxt = '0;
        if (pass_r) begin
          state_nxt = S_AZI;
        end else if (mag_c != '0) begin
          state_nxt = S_SEC;
          cnt_nxt   = shbe_pkg::CNT_W'(1);
        end else if (has_rec) begin
          state_nxt = S_SEED;
        end else begin
          state_nxt = post_state;
        end
      end
      S_SEC: begin
        cmd.a_sel = shbe_pkg::A_PREV;
        unique case (sub_r)
          3'd0: begin cmd.op = shbe_pkg::OP_MUL; cmd.b_sel = shbe_pkg::B_SN; end
          3'd1: begin cmd.op = shbe_pkg::OP_RND; cmd.wb = shbe_pkg::WB_PREV; end
          3'd2: begin cmd.op = shbe_pkg::OP_MUL; cmd.b_sel = shbe_pkg::B_C1; end
          default: begin
            cmd.op = shbe_pkg::OP_RND; cmd.rnd24 = 1'b1; cmd.wb = shbe_pkg::WB_PREV_NEG;
          end
        endcase
        if (sub_r == 3'd3) begin
          sub_nxt = '0;
          if (cnt_r == mag_c) state_nxt = has_rec ? S_SEED : post_state;
          else cnt_nxt = cnt_r + 1'b1;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      S_SEED: begin
        unique case (sub_r)
          3'd0: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_PREV; cmd.b_sel = shbe_pkg::B_CX;
          end
          3'd1: begin cmd.op = shbe_pkg::OP_RND; cmd.wb = shbe_pkg::WB_T; end
          3'd2: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_T; cmd.b_sel = shbe_pkg::B_C0;
          end
          default: begin
            cmd.op = shbe_pkg::OP_RND; cmd.rnd24 = 1'b1; cmd.wb = shbe_pkg::WB_CUR;
          end
        endcase
        if (sub_r == 3'd3) begin
          sub_nxt = '0;
          cnt_nxt = mag_c + shbe_pkg::CNT_W'(2);
          state_nxt = ((mag_c + shbe_pkg::CNT_W'(2)) > band_c) ? post_state : S_REC;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      S_REC: begin
        unique case (sub_r)
          3'd0: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_CUR; cmd.b_sel = shbe_pkg::B_CX;
          end
          3'd1: begin cmd.op = shbe_pkg::OP_RND; cmd.wb = shbe_pkg::WB_T; end
          3'd2: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_PREV; cmd.b_sel = shbe_pkg::B_CB;
          end
          3'd3: begin
            cmd.op = shbe_pkg::OP_RND; cmd.rnd24 = 1'b1; cmd.wb = shbe_pkg::WB_T_SUB;
          end
          3'd4: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_T; cmd.b_sel = shbe_pkg::B_CA;
          end
          default: begin
            cmd.op = shbe_pkg::OP_RND; cmd.rnd24 = 1'b1; cmd.wb = shbe_pkg::WB_SHIFT;
          end
        endcase
        if (sub_r == 3'd5) begin
          sub_nxt = '0;
          if (cnt_r == band_c) state_nxt = post_state;
          else cnt_nxt = cnt_r + 1'b1;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      S_PHI: begin
        cmd.op    = shbe_pkg::OP_PHI;
        cnt_nxt   = shbe_pkg::CNT_W'(shbe_pkg::MOD_STEPS - 1);
        pass_nxt  = 1'b1;
        state_nxt = S_MOD;
      end
      S_AZI: begin
        unique case (sub_r)
          3'd0: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_RES;
            cmd.b_sel = shbe_pkg::B_SQRT2;
          end
          3'd1: begin cmd.op = shbe_pkg::OP_RND; cmd.wb = shbe_pkg::WB_T; end
          3'd2: begin
            cmd.op = shbe_pkg::OP_MUL; cmd.a_sel = shbe_pkg::A_T; cmd.b_sel = shbe_pkg::B_TRG;
          end
          default: begin cmd.op = shbe_pkg::OP_RND; cmd.wb = shbe_pkg::WB_T; end
        endcase
        if (sub_r == 3'd3) begin
          sub_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          sub_nxt = sub_r + 1'b1;
        end
      end
      default: begin
        if (!status.out_hold) begin
          cmd.op    = shbe_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sub_r   <= '0;
      cnt_r   <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
      cnt_r   <= cnt_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

/* design/sh_basis_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh_basis_eval
// Real spherical harmonic basis sample Y(l,m) at (theta, phi).
// ----------------------------------------------------------------------------
// One request is worked on at a time. An item goes through the polar
// CORDIC pass (4 modulo steps, a fold, 30 rotations, a capture), then the
// sectoral steps, the recurrence where l > |m|, and, for m other than zero,
// the azimuth CORDIC pass and the azimuth factor, and last the load of the
// output register. The shared rotator and the single multiplier serialise
// these steps. A rejected order goes from the check straight to the output
// register. The result waits in an output register, so a new request is
// taken while it is held.
// ----------------------------------------------------------------------------
module sh_basis_eval (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [shbe_pkg::BAND_IN_W-1:0]        in_band,
  input  logic signed [shbe_pkg::ORDER_W-1:0]   in_order,
  input  logic [shbe_pkg::POLAR_W-1:0]          in_polar_angle,
  input  logic [shbe_pkg::AZIM_W-1:0]           in_azimuth_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [shbe_pkg::VALUE_W-1:0]   out_basis_value,
  output logic                                  out_bad_order
);

  shbe_pkg::cmd_t    cmd;
  shbe_pkg::status_t status;

  // Sequencer.
  shbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and output register.
  shbe_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_band          (in_band),
    .in_order         (in_order),
    .in_polar_angle   (in_polar_angle),
    .in_azimuth_angle (in_azimuth_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_basis_value  (out_basis_value),
    .out_bad_order    (out_bad_order)
  );

endmodule

/* sim/sh_basis_eval_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh_basis_eval_tb
// Self-checking bench for the spherical harmonic basis evaluator. Requests are
// driven over the valid/ready input channel. A fixed-point model of the
// CORDIC and the normalised Legendre recurrence predicts every result beat,
// and a scoreboard compares it field by field. Both channels idle at random
// in several phases.
// ----------------------------------------------------------------------------
module sh_basis_eval_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 1130;
  localparam int PI_Q13         = 25736;
  localparam int TWO_PI_Q13     = 51472;

  typedef struct {
    logic signed [shbe_pkg::VALUE_W-1:0] basis_value;
    logic                                bad_order;
  } sh_sample_t;

  // Floor shift and round-half-up shift on wide signed values.
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(input longint v, input int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b, input int s);
    return round_shr(a * b, s);
  endfunction

  function automatic longint int_sqrt(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint root_ratio(input longint unsigned n, input longint unsigned d);
    return int_sqrt((n << 48) / d);
  endfunction

  // Cosine and sine of a non-negative Q.30 angle by rotation-mode CORDIC.
  task automatic cordic_trig(input longint ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint ny;
    bit     flip;
    x    = shbe_pkg::CORDIC_GAIN;
    y    = 0;
    flip = 0;
    z    = ang % shbe_pkg::Q30_TWO_PI;
    if (z > shbe_pkg::Q30_PI) z -= shbe_pkg::Q30_TWO_PI;
    if (z > shbe_pkg::Q30_HALF_PI) begin
      z -= shbe_pkg::Q30_PI;
      flip = 1;
    end else if (z < -shbe_pkg::Q30_HALF_PI) begin
      z += shbe_pkg::Q30_PI;
      flip = 1;
    end
    for (int i = 0; i < shbe_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        ny = y + floor_shr(x, i);
        z -= longint'(shbe_pkg::ATAN_TAB[i]);
      end else begin
        nx = x + floor_shr(y, i);
        ny = y - floor_shr(x, i);
        z += longint'(shbe_pkg::ATAN_TAB[i]);
      end
      x = nx;
      y = ny;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Expected sample for one request.
  task automatic predict_sample(input logic [shbe_pkg::BAND_IN_W-1:0] l_in,
                                input logic signed [shbe_pkg::ORDER_W-1:0] m_in,
                                input logic [shbe_pkg::POLAR_W-1:0] th,
                                input logic [shbe_pkg::AZIM_W-1:0] ph,
                                output sh_sample_t res);
    longint l, m, ma, cx, sn, prv, cur, nxt, v, ca, cb, tc, ts;
    l  = l_in;
    m  = m_in;
    ma = (m < 0) ? -m : m;
    if (l >= shbe_pkg::MAX_BANDS || ma > l) begin
      res.basis_value = '0;
      res.bad_order   = 1'b1;
      return;
    end
    cordic_trig(longint'(th) << shbe_pkg::ANG_SHIFT, cx, sn);
    if (sn < 0) sn = -sn;
    prv = shbe_pkg::Q30_INV_S4PI;
    for (longint k = 1; k <= ma; k++) begin
      prv = fx_mul(prv, sn, 30);
      prv = -fx_mul(prv, root_ratio(2 * k + 1, 2 * k), 24);
    end
    v = prv;
    if (l > ma) begin
      cur = fx_mul(fx_mul(prv, cx, 30), root_ratio(2 * ma + 3, 1), 24);
      for (longint k = ma + 2; k <= l; k++) begin
        ca  = root_ratio(4 * k * k - 1, k * k - ma * ma);
        cb  = root_ratio((k - 1) * (k - 1) - ma * ma, 4 * (k - 1) * (k - 1) - 1);
        nxt = fx_mul(fx_mul(cur, cx, 30) - fx_mul(prv, cb, 24), ca, 24);
        prv = cur;
        cur = nxt;
      end
      v = cur;
    end
    if (m != 0) begin
      cordic_trig((ma * longint'(ph)) << shbe_pkg::ANG_SHIFT, tc, ts);
      v = fx_mul(v, shbe_pkg::Q30_SQRT2, 30);
      v = fx_mul(v, (m > 0) ? tc : ts, 30);
    end
    v = round_shr(v, shbe_pkg::OUT_SHIFT);
    if (v > shbe_pkg::VAL_MAX) v = shbe_pkg::VAL_MAX;
    if (v < shbe_pkg::VAL_MIN) v = shbe_pkg::VAL_MIN;
    res.basis_value = shbe_pkg::VALUE_W'(v);
    res.bad_order   = 1'b0;
  endtask

  // Scoreboard of predicted samples, oldest first.
  class sample_scoreboard;
    sh_sample_t pending[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    task note_request(input logic [shbe_pkg::BAND_IN_W-1:0] l,
                      input logic signed [shbe_pkg::ORDER_W-1:0] m,
                      input logic [shbe_pkg::POLAR_W-1:0] th,
                      input logic [shbe_pkg::AZIM_W-1:0] ph);
      sh_sample_t s;
      predict_sample(l, m, th, ph, s);
      pending.push_back(s);
    endtask

    function void check_sample(input logic signed [shbe_pkg::VALUE_W-1:0] val,
                               input logic bad);
      sh_sample_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat: basis_value %0d bad_order %0b", val, bad);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (val !== e.basis_value) begin
        $error("basis_value: expected %0d, actual %0d", e.basis_value, val);
        errors++;
      end
      if (bad !== e.bad_order) begin
        $error("bad_order: expected %0b, actual %0b", e.bad_order, bad);
        errors++;
      end
    endfunction
  endclass

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_ready;
  logic [shbe_pkg::BAND_IN_W-1:0]        in_band;
  logic signed [shbe_pkg::ORDER_W-1:0]   in_order;
  logic [shbe_pkg::POLAR_W-1:0]          in_polar_angle;
  logic [shbe_pkg::AZIM_W-1:0]           in_azimuth_angle;
  logic                                  out_valid;
  logic                                  out_ready;
  logic signed [shbe_pkg::VALUE_W-1:0]   out_basis_value;
  logic                                  out_bad_order;

  sample_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  int  idle_cycles;

  sh_basis_eval i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_band          (in_band),
    .in_order         (in_order),
    .in_polar_angle   (in_polar_angle),
    .in_azimuth_angle (in_azimuth_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_basis_value  (out_basis_value),
    .out_bad_order    (out_bad_order)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stalls, and every accepted beat is checked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_sample(out_basis_value, out_bad_order);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one request and holds it until accepted. Valid drops only
  // while the sender idles, so back-to-back beats keep it high.
  task automatic send_request(input logic [shbe_pkg::BAND_IN_W-1:0] l,
                              input logic signed [shbe_pkg::ORDER_W-1:0] m,
                              input logic [shbe_pkg::POLAR_W-1:0] th,
                              input logic [shbe_pkg::AZIM_W-1:0] ph);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_band          <= l;
    in_order         <= m;
    in_polar_angle   <= th;
    in_azimuth_angle <= ph;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(l, m, th, ph);
  endtask

  // Mostly valid orders with angles in range; some bad orders and raw angles.
  task automatic send_random;
    logic [shbe_pkg::BAND_IN_W-1:0]      l;
    logic signed [shbe_pkg::ORDER_W-1:0] m;
    logic [shbe_pkg::POLAR_W-1:0]        th;
    logic [shbe_pkg::AZIM_W-1:0]         ph;
    int                                  lim;
    l = shbe_pkg::BAND_IN_W'($urandom_range(shbe_pkg::MAX_BANDS - 1));
    if ($urandom_range(9) == 0) begin
      m = shbe_pkg::ORDER_W'($urandom);
    end else begin
      lim = int'(l);
      m   = shbe_pkg::ORDER_W'($signed($urandom_range(2 * lim)) - lim);
    end
    if ($urandom_range(9) == 0) begin
      th = shbe_pkg::POLAR_W'($urandom);
      ph = shbe_pkg::AZIM_W'($urandom);
    end else begin
      th = shbe_pkg::POLAR_W'($urandom_range(PI_Q13));
      ph = shbe_pkg::AZIM_W'($urandom_range(TWO_PI_Q13));
    end
    send_request(l, m, th, ph);
  endtask

  initial begin
    sb               = new();
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_band          = '0;
    in_order         = '0;
    in_polar_angle   = '0;
    in_azimuth_angle = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, order zero, signs of m, bad orders, raw angles.
    send_request(0, 0, 0, 0);
    send_request(7, 0, PI_Q13, 0);
    send_request(7, 7, PI_Q13 / 2, TWO_PI_Q13 / 8);
    send_request(7, -7, PI_Q13 / 2, TWO_PI_Q13 / 8);
    send_request(7, 7, '1, '1);
    send_request(7, -7, '1, '1);
    send_request(1, 1, 12000, 51472);
    send_request(1, -1, 12000, 3000);
    send_request(0, 1, 100, 100);
    send_request(0, -8, 100, 100);
    send_request(3, -4, 9000, 9000);
    send_request(5, 6, 9000, 9000);
    send_request(6, 3, 30000, 60000);
    send_request(4, -2, PI_Q13, TWO_PI_Q13);
    send_request(2, 2, 1, 1);
    send_request(7, 1, 26000, 40000);
    send_request(3, 0, 16384, 32768);
    send_request(5, -5, 2000, 65000);

    // Random phases with different idling mixes.
    for (int ph_i = 0; ph_i < 5; ph_i++) begin
      case (ph_i)
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        3:       begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) send_random();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
